>>> src/fefc_pkg.sv
// Package for the filtered elastic flow counter.
// Holds the state machine type, register indexes and fixed field widths.
// No dependencies.
package fefc_pkg;

   localparam int KEY_LO_W = 64;
   localparam int KEY_HI_W = 40;
   localparam int VOTE_W   = 32;
   localparam int CNT_W    = 8;
   localparam int REACH_W  = 12;

   localparam logic [1:0] CSR_FILTER_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_REFRESH_LIMIT    = 2'd1;
   localparam logic [1:0] CSR_VOTE_THRESHOLD   = 2'd2;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FREAD,
      ST_FUPD,
      ST_REFRESH,
      ST_TREAD,
      ST_TUPD,
      ST_QREAD,
      ST_QDONE,
      ST_OUT
   } state_type;

endpackage

>>> src/filtered_elastic_flow_counter.sv
// Top level of the filtered elastic flow counter.
// Uses fefc_pkg for the state type, register indexes and widths.
//
// channel | ports                                | direction
// req     | req_valid, req_stall, req_* fields   | in  (req_stall out)
// rsp     | rsp_valid, rsp_stall, rsp_* fields   | out (rsp_stall in)
// csr     | csr_write, csr_index, csr_data       | in
//
// One item at a time. A query scans the table row (ST_QREAD) before rsp_valid rises. An insert
// first reads and updates the filter (ST_FREAD, ST_FUPD); if it passes, it scans the row for a
// hit or a free slot (ST_TREAD) and, if neither is found, runs the eviction scan (ST_TUPD).
// A refresh pass over the filter columns may follow ST_FUPD. Every item ends with ST_QREAD.
// req_stall is high outside ST_IDLE: during the clearing pass that runs after reset before the
// first word is accepted, and from acceptance until the result is taken. The result holds while rsp_stall is high.
module filtered_elastic_flow_counter #(
   parameter int FILTER_COLS = 1024,
   parameter int TABLE_ROWS  = 1024,
   parameter int TABLE_COLS  = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [63:0] req_flow_key_low,
   input  logic [39:0] req_flow_key_high,
   input  logic [9:0]  req_filter_slot_a,
   input  logic [9:0]  req_filter_slot_b,
   input  logic [9:0]  req_filter_slot_c,
   input  logic [9:0]  req_table_row_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_passed_filter,
   output logic        rsp_placed,
   output logic        rsp_filter_refreshed,
   output logic [31:0] rsp_vote_count,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_data
);

   localparam int FC_W   = $clog2(FILTER_COLS);
   localparam int TR_W   = $clog2(TABLE_ROWS);
   localparam int TC_W   = (TABLE_COLS > 1) ? $clog2(TABLE_COLS) : 1;
   localparam int TE_W   = TR_W + TC_W;
   localparam int TE_N   = TABLE_ROWS * (2 ** TC_W);
   localparam int CLR_N  = (TE_N > FILTER_COLS) ? TE_N : FILTER_COLS;
   localparam int CLR_W  = $clog2(CLR_N + 1);
   localparam int FW     = fefc_pkg::CNT_W + 1;
   localparam int EW     = fefc_pkg::KEY_LO_W + fefc_pkg::KEY_HI_W + fefc_pkg::VOTE_W;
   localparam int F_RECIP = ((1 << 20) + FILTER_COLS - 1) / FILTER_COLS;
   localparam int R_RECIP = ((1 << 20) + TABLE_ROWS - 1) / TABLE_ROWS;

   // configuration
   logic [7:0]  filt_thr_ff;
   logic [11:0] ref_lim_ff;
   logic [7:0]  vote_thr_ff;

   // filter memories: one per row, {flag, count}
   logic [FW-1:0] fmem0 [FILTER_COLS];
   logic [FW-1:0] fmem1 [FILTER_COLS];
   logic [FW-1:0] fmem2 [FILTER_COLS];
   logic [FW-1:0] frd0_ff, frd1_ff, frd2_ff;
   // table memory {votes, key_high, key_low}; row negative votes
   logic [EW-1:0]     tmem [TE_N];
   logic [EW-1:0]     trd_ff;
   logic [31:0]       nmem [TABLE_ROWS];
   logic [31:0]       nrd_ff;

   fefc_pkg::state_type st_ff, st_in;
   logic [CLR_W-1:0] cnt_ff, cnt_in;

   logic [fefc_pkg::REACH_W-1:0] reached_ff, reached_in;

   // latched request
   logic [63:0] klo_ff;
   logic [39:0] khi_ff;
   logic [FC_W-1:0] fa_ff, fb_ff, fc_ff;
   logic [TR_W-1:0] row_ff;

   // scan results
   logic          pass_ff, pass_in;
   logic          ref_ff, ref_in;
   logic          hit_ff, hit_in;
   logic [TC_W-1:0] hit_col_ff, hit_col_in;
   logic          emp_ff, emp_in;
   logic [TC_W-1:0] emp_col_ff, emp_col_in;
   logic          ev_ff, ev_in;
   logic [TC_W-1:0] ev_col_ff, ev_col_in;
   logic [31:0]   hit_votes_ff, hit_votes_in;
   logic [31:0]   neg_ff, neg_in;
   logic          placed_ff, placed_in;

   // outputs
   logic        out_pass_ff, out_pass_in;
   logic        out_placed_ff, out_placed_in;
   logic        out_ref_ff, out_ref_in;
   logic [31:0] out_votes_ff, out_votes_in;

   // memory write controls
   logic [FC_W-1:0] fwa0, fwa1, fwa2;
   logic [FW-1:0] fwd0, fwd1, fwd2;
   logic          fwe0, fwe1, fwe2;
   logic [FC_W-1:0] fra0, fra1, fra2;
   logic          twe;
   logic [TE_W-1:0] twa, tra;
   logic [EW-1:0] twd;
   logic          nwe;
   logic [TR_W-1:0] nwa;
   logic [31:0]   nwd;

   logic req_acc;
   assign req_acc = req_valid && !req_stall;
   assign req_stall = (st_ff != fefc_pkg::ST_IDLE);
   assign rsp_valid = (st_ff == fefc_pkg::ST_OUT);
   assign rsp_passed_filter    = out_pass_ff;
   assign rsp_placed           = out_placed_ff;
   assign rsp_filter_refreshed = out_ref_ff;
   assign rsp_vote_count       = out_votes_ff;

   // decoded read words
   logic [7:0] c0, c1, c2, mn;
   logic       f0, f1, f2;
   assign c0 = frd0_ff[7:0]; assign f0 = frd0_ff[8];
   assign c1 = frd1_ff[7:0]; assign f1 = frd1_ff[8];
   assign c2 = frd2_ff[7:0]; assign f2 = frd2_ff[8];
   assign mn = (c0 < c1) ? ((c2 < c0) ? c2 : c0) : ((c2 < c1) ? c2 : c1);

   logic [31:0] e_votes;
   logic [39:0] e_khi;
   logic [63:0] e_klo;
   assign e_votes = trd_ff[EW-1 -: 32];
   assign e_khi   = trd_ff[103:64];
   assign e_klo   = trd_ff[63:0];

   logic [TC_W-1:0] col;
   assign col = cnt_ff[TC_W-1:0];
   logic last_col;
   assign last_col = (cnt_ff == CLR_W'(TABLE_COLS - 1));

   function automatic logic [7:0] sat_inc(input logic [7:0] v);
      sat_inc = (v == 8'hFF) ? v : v + 8'd1;
   endfunction

   // fold a hashed index into range: reciprocal multiply, exact for 10-bit inputs
   function automatic logic [FC_W-1:0] fold_col(input logic [9:0] x);
      logic [31:0] q;
      logic [31:0] r;
      q = (32'(x) * 32'(F_RECIP)) >> 20;
      r = 32'(x) - q * 32'(FILTER_COLS);
      fold_col = FC_W'(r);
   endfunction

   function automatic logic [TR_W-1:0] fold_row(input logic [9:0] x);
      logic [31:0] q;
      logic [31:0] r;
      q = (32'(x) * 32'(R_RECIP)) >> 20;
      r = 32'(x) - q * 32'(TABLE_ROWS);
      fold_row = TR_W'(r);
   endfunction

   always_comb begin
      logic [7:0] n0, n1, n2;
      logic       u0, u1, u2;
      logic [3:0] add;
      logic [12:0] rsum;
      logic [39:0] prod;
      logic        match;
      n0 = 8'd0; n1 = 8'd0; n2 = 8'd0;
      u0 = 1'b0; u1 = 1'b0; u2 = 1'b0;
      add = 4'd0; rsum = 13'd0; prod = 40'd0; match = 1'b0;
      st_in = st_ff; cnt_in = cnt_ff; reached_in = reached_ff;
      pass_in = pass_ff; ref_in = ref_ff; placed_in = placed_ff;
      hit_in = hit_ff; hit_col_in = hit_col_ff; hit_votes_in = hit_votes_ff;
      emp_in = emp_ff; emp_col_in = emp_col_ff;
      ev_in = ev_ff; ev_col_in = ev_col_ff; neg_in = neg_ff;
      out_pass_in = out_pass_ff; out_placed_in = out_placed_ff;
      out_ref_in = out_ref_ff; out_votes_in = out_votes_ff;
      fwe0 = 1'b0; fwe1 = 1'b0; fwe2 = 1'b0;
      fwa0 = fa_ff; fwa1 = fb_ff; fwa2 = fc_ff;
      fwd0 = '0; fwd1 = '0; fwd2 = '0;
      fra0 = fa_ff; fra1 = fb_ff; fra2 = fc_ff;
      twe = 1'b0; twa = {row_ff, col}; twd = '0;
      tra = {row_ff, col};
      nwe = 1'b0; nwa = row_ff; nwd = '0;
      case (st_ff)
         fefc_pkg::ST_CLEAR: begin
            if (cnt_ff < CLR_W'(FILTER_COLS)) begin
               fwe0 = 1'b1; fwe1 = 1'b1; fwe2 = 1'b1;
               fwa0 = cnt_ff[FC_W-1:0]; fwa1 = cnt_ff[FC_W-1:0];
               fwa2 = cnt_ff[FC_W-1:0];
            end
            if (cnt_ff < CLR_W'(TE_N)) begin
               twe = 1'b1; twa = cnt_ff[TE_W-1:0];
            end
            if (cnt_ff < CLR_W'(TABLE_ROWS)) begin
               nwe = 1'b1; nwa = cnt_ff[TR_W-1:0];
            end
            cnt_in = cnt_ff + CLR_W'(1);
            if (cnt_ff == CLR_W'(CLR_N - 1)) st_in = fefc_pkg::ST_IDLE;
         end
         fefc_pkg::ST_IDLE: begin
            if (req_acc) begin
               pass_in = 1'b0; ref_in = 1'b0; placed_in = 1'b0;
               st_in = (req_op == fefc_pkg::OP_INSERT) ? fefc_pkg::ST_FREAD
                                                        : fefc_pkg::ST_QREAD;
               cnt_in = '0;
               hit_in = 1'b0; emp_in = 1'b0; ev_in = 1'b0;
            end
         end
         fefc_pkg::ST_FREAD: st_in = fefc_pkg::ST_FUPD;
         fefc_pkg::ST_FUPD: begin
            pass_in = !((mn < filt_thr_ff) && !(f0 && f1 && f2));
            n0 = c0; n1 = c1; n2 = c2;
            if (mn < filt_thr_ff) begin
               if (c0 == c1 && c1 == c2) begin
                  u0 = 1'b1; u1 = 1'b1; u2 = 1'b1;
                  if (sat_inc(c0) == filt_thr_ff) add = 4'd3;
               end else if (c0 == c1 && c1 == mn) begin
                  u0 = 1'b1; u1 = 1'b1;
                  if (sat_inc(c0) == filt_thr_ff) add = 4'd2;
               end else if (c1 == c2 && c2 == mn) begin
                  u1 = 1'b1; u2 = 1'b1;
                  if (sat_inc(c1) == filt_thr_ff) add = 4'd2;
               end else if (c0 == c2 && c2 == mn) begin
                  u0 = 1'b1; u2 = 1'b1;
                  if (sat_inc(c0) == filt_thr_ff) add = 4'd2;
               end else if (c0 == mn) u0 = 1'b1;
               else if (c1 == mn) u1 = 1'b1;
               else u2 = 1'b1;
            end
            if (u0) n0 = sat_inc(c0);
            if (u1) n1 = sat_inc(c1);
            if (u2) n2 = sat_inc(c2);
            fwe0 = u0; fwe1 = u1; fwe2 = u2;
            fwd0 = {f0, n0}; fwd1 = {f1, n1}; fwd2 = {f2, n2};
            rsum = {1'b0, reached_ff} + 13'(add);
            reached_in = rsum[12] ? 12'hFFF : rsum[11:0];
            cnt_in = '0;
            if (reached_in >= ref_lim_ff) begin
               ref_in = 1'b1;
               reached_in = '0;
               st_in = fefc_pkg::ST_REFRESH;
            end else if (pass_in) st_in = fefc_pkg::ST_TREAD;
            else st_in = fefc_pkg::ST_QREAD;
         end
         fefc_pkg::ST_REFRESH: begin
            // read column cnt, write back column cnt-1 from last cycle's read
            if (cnt_ff < CLR_W'(FILTER_COLS)) begin
               fra0 = cnt_ff[FC_W-1:0];
               fra1 = cnt_ff[FC_W-1:0];
               fra2 = cnt_ff[FC_W-1:0];
            end
            if (cnt_ff != '0) begin
               fwe0 = 1'b1; fwe1 = 1'b1; fwe2 = 1'b1;
               fwa0 = FC_W'(cnt_ff - CLR_W'(1));
               fwa1 = FC_W'(cnt_ff - CLR_W'(1));
               fwa2 = FC_W'(cnt_ff - CLR_W'(1));
               fwd0 = {(c0 >= filt_thr_ff), 8'd0};
               fwd1 = {(c1 >= filt_thr_ff), 8'd0};
               fwd2 = {(c2 >= filt_thr_ff), 8'd0};
            end
            cnt_in = cnt_ff + CLR_W'(1);
            if (cnt_ff == CLR_W'(FILTER_COLS)) begin
               cnt_in = '0;
               st_in = pass_ff ? fefc_pkg::ST_TREAD : fefc_pkg::ST_QREAD;
            end
         end
         fefc_pkg::ST_TREAD: begin
            // cnt counts scan steps; data for column cnt-1 is valid when cnt>0
            tra = {row_ff, TC_W'(cnt_ff)};
            if (cnt_ff != '0) begin
               match = (e_votes != 0) && (e_klo == klo_ff) && (e_khi == khi_ff);
               if (match && !hit_in) begin
                  hit_in = 1'b1; hit_col_in = TC_W'(cnt_ff - CLR_W'(1));
                  hit_votes_in = e_votes;
               end
               if (e_votes == 0 && !emp_in) begin
                  emp_in = 1'b1; emp_col_in = TC_W'(cnt_ff - CLR_W'(1));
               end
            end
            cnt_in = cnt_ff + CLR_W'(1);
            if (cnt_ff == CLR_W'(TABLE_COLS)) begin
               cnt_in = '0;
               placed_in = hit_in || emp_in;
               neg_in = (nrd_ff == 32'hFFFF_FFFF) ? nrd_ff : nrd_ff + 32'd1;
               if (hit_in || emp_in) st_in = fefc_pkg::ST_QREAD;
               else begin
                  tra = {row_ff, TC_W'(0)};
                  st_in = fefc_pkg::ST_TUPD;
               end
               if (hit_in) begin
                  twe = 1'b1; twa = {row_ff, hit_col_in};
                  twd = {(hit_votes_in == 32'hFFFF_FFFF) ? hit_votes_in
                                                          : hit_votes_in + 32'd1,
                         khi_ff, klo_ff};
               end else if (emp_in) begin
                  twe = 1'b1; twa = {row_ff, emp_col_in};
                  twd = {32'd1, khi_ff, klo_ff};
               end
            end
         end
         fefc_pkg::ST_TUPD: begin
            // eviction scan over the full row
            tra = {row_ff, TC_W'(cnt_ff + CLR_W'(1))};
            prod = 40'(vote_thr_ff) * 40'(e_votes);
            if (!ev_ff && e_votes != 0 && {8'd0, neg_ff} > prod) begin
               ev_in = 1'b1; ev_col_in = col;
            end
            cnt_in = cnt_ff + CLR_W'(1);
            if (last_col) begin
               cnt_in = '0;
               placed_in = ev_in;
               nwe = 1'b1;
               nwd = ev_in ? 32'd0 : neg_ff;
               if (ev_in) begin
                  twe = 1'b1; twa = {row_ff, ev_col_in};
                  twd = {32'd1, khi_ff, klo_ff};
               end
               st_in = fefc_pkg::ST_QREAD;
            end
         end
         fefc_pkg::ST_QREAD: begin
            tra = {row_ff, TC_W'(cnt_ff)};
            if (cnt_ff != '0) begin
               match = (e_votes != 0) && (e_klo == klo_ff) && (e_khi == khi_ff);
               if (match && !hit_in) begin
                  hit_in = 1'b1; hit_votes_in = e_votes;
               end
            end else begin
               hit_in = 1'b0;
            end
            cnt_in = cnt_ff + CLR_W'(1);
            if (cnt_ff == CLR_W'(TABLE_COLS)) begin
               cnt_in = '0;
               out_pass_in = pass_ff;
               out_placed_in = pass_ff && placed_ff;
               out_ref_in = ref_ff;
               out_votes_in = hit_in ? hit_votes_in : 32'd0;
               st_in = fefc_pkg::ST_OUT;
            end
         end
         fefc_pkg::ST_OUT: begin
            if (!rsp_stall) st_in = fefc_pkg::ST_IDLE;
         end
         default: st_in = fefc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= fefc_pkg::ST_CLEAR;
         cnt_ff <= '0;
         reached_ff <= '0;
         filt_thr_ff <= 8'd3;
         ref_lim_ff <= 12'd1536;
         vote_thr_ff <= 8'd8;
      end else begin
         st_ff <= st_in;
         cnt_ff <= cnt_in;
         reached_ff <= reached_in;
         if (csr_write) begin
            case (csr_index)
               fefc_pkg::CSR_FILTER_THRESHOLD: filt_thr_ff <= csr_data[7:0];
               fefc_pkg::CSR_REFRESH_LIMIT:    ref_lim_ff <= csr_data;
               fefc_pkg::CSR_VOTE_THRESHOLD:   vote_thr_ff <= csr_data[7:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         klo_ff <= req_flow_key_low; khi_ff <= req_flow_key_high;
         fa_ff <= fold_col(req_filter_slot_a);
         fb_ff <= fold_col(req_filter_slot_b);
         fc_ff <= fold_col(req_filter_slot_c);
         row_ff <= fold_row(req_table_row_index);
      end
      pass_ff <= pass_in; ref_ff <= ref_in;
      hit_ff <= hit_in; hit_col_ff <= hit_col_in; hit_votes_ff <= hit_votes_in;
      emp_ff <= emp_in; emp_col_ff <= emp_col_in;
      ev_ff <= ev_in; ev_col_ff <= ev_col_in; neg_ff <= neg_in;
      placed_ff <= placed_in;
      out_pass_ff <= out_pass_in;
      out_placed_ff <= out_placed_in;
      out_ref_ff <= out_ref_in;
      out_votes_ff <= out_votes_in;
   end

   // memories
   always_ff @(posedge clock) begin
      if (fwe0) fmem0[fwa0] <= fwd0;
      if (fwe1) fmem1[fwa1] <= fwd1;
      if (fwe2) fmem2[fwa2] <= fwd2;
      frd0_ff <= fmem0[fra0];
      frd1_ff <= fmem1[fra1];
      frd2_ff <= fmem2[fra2];
   end

   always_ff @(posedge clock) begin
      if (twe) tmem[twa] <= twd;
      trd_ff <= tmem[tra];
   end

   always_ff @(posedge clock) begin
      if (nwe) nmem[nwa] <= nwd;
      nrd_ff <= nmem[row_ff];
   end

endmodule
